// ----- hw/rtl/f2dt_pkg.sv -----
`timescale 1ns / 1ps
package f2dt_pkg;

   // Integer part holds at most 31 bits, which needs 10 decimal digits.
   localparam int INT_BITS   = 31;
   localparam int INT_DIGITS = 10;
   localparam int NBITS_W    = 5;
   localparam int FRAC_BITS  = 24;
   localparam int FCNT_W     = 3;
   localparam int ROOM_W     = 6;

   localparam logic [7:0] EXP_BIAS      = 8'd127;
   localparam logic [7:0] EXP_BIAS_M1   = 8'd126;
   localparam logic [7:0] EXP_TOO_LARGE = 8'd158;
   localparam logic [7:0] EXP_TOO_SMALL = 8'd104;

   localparam logic [ROOM_W-1:0] CHAR_CAP = 6'd14;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_NINE  = 8'h39;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;
   localparam logic [7:0] ASCII_POINT = 8'h2E;
   localparam logic [7:0] CHAR_NONE   = 8'h00;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_TOO_SMALL = 2'd2
   } conv_status_type;

   typedef struct packed {
      logic               start;
      logic [NBITS_W-1:0] nbits;
   } bcd_cmd_type;

   typedef struct packed {
      logic       done;
      logic [3:0] ndig;
   } bcd_stat_type;

   typedef struct packed {
      logic              start;
      logic [FCNT_W-1:0] budget;
   } frac_cmd_type;

   typedef struct packed {
      logic              done;
      logic [FCNT_W-1:0] nkeep;
   } frac_stat_type;

endpackage

// ----- hw/rtl/float_to_decimal_text.sv -----
`timescale 1ns / 1ps
// Channel   Ports   Direction  Contents
// request   req_    in         tdata[31:0] float_bits
// response  rsp_    out        tdata[7:0] char_out, tlast last_char, tuser[1:0] status
//
// A request runs through decode, then the BCD unit over b integer bits (e + 1 for an unbiased
// exponent e of 0 or more, else 0), the fraction unit over d fraction digits (the whole digit
// budget, also for a zero fraction), and then sends c characters.
// A too large or too small request skips both units and sends one character. req_tready is high only while idle.
// Reset clears the sequencer, both units and the output valid; there is no clearing pass.
// A low rsp_tready holds the current character and pauses the sequencer while it sends.
module float_to_decimal_text #(
   parameter int MAX_FRAC_DIGITS = 7,
   parameter int TEXT_BUFFER_LEN = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] float_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] char_out
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import f2dt_pkg::*;

   localparam int FIDX_W = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;
   localparam logic [ROOM_W-1:0] BUF_ROOM  = ROOM_W'(TEXT_BUFFER_LEN - 1);
   localparam logic [ROOM_W-1:0] FRAC_MAXR = ROOM_W'(MAX_FRAC_DIGITS);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_INT, S_BUDGET, S_FRAC,
      S_ERR, S_SIGN, S_IDIG, S_DOT, S_FDIG
   } state_type;

   state_type              state_ff;
   logic [31:0]            bits_ff;
   logic                   neg_ff;
   conv_status_type        err_ff;
   logic [FRAC_BITS-1:0]   fpart_ff;
   logic [3:0]             nint_ff;
   logic [3:0]             iptr_ff;
   logic [FIDX_W-1:0]      fptr_ff;
   logic [FCNT_W-1:0]      nkeep_ff;
   bcd_cmd_type            bcd_cmd_ff;
   frac_cmd_type           frac_cmd_ff;
   logic                   rsp_tvalid_ff;
   logic [7:0]             rsp_char_ff;
   logic                   rsp_last_ff;
   conv_status_type        rsp_status_ff;

   bcd_stat_type           bcd_stat;
   logic [INT_DIGITS*4-1:0] bcd_digits;
   frac_stat_type          frac_stat;
   logic [3:0]             frac_digit;

   logic [7:0]             exp8;
   logic [FRAC_BITS-1:0]   mant;
   logic                   is_zero;
   logic                   too_large;
   logic                   too_small;
   logic [NBITS_W-1:0]     nbits_dec;
   logic [FRAC_BITS-1:0]   fpart_dec;
   logic [ROOM_W-1:0]      n_before;
   logic [ROOM_W-1:0]      room_buf;
   logic [ROOM_W-1:0]      room_cap;
   logic [ROOM_W-1:0]      budget;
   logic                   out_free;
   logic                   rsp_load;
   logic                   frac_last;

   f2dt_bcd_unit u_bcd (
      .clock (clock),
      .reset (reset),
      .cmd   (bcd_cmd_ff),
      .value ({1'b1, bits_ff[22:0], 7'b0}),
      .stat  (bcd_stat),
      .bcd   (bcd_digits)
   );

   f2dt_frac_unit #(
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_frac (
      .clock    (clock),
      .reset    (reset),
      .cmd      (frac_cmd_ff),
      .fpart    (fpart_ff),
      .stat     (frac_stat),
      .rd_idx   (fptr_ff),
      .rd_digit (frac_digit)
   );

   // split the value into integer bit count and a 24-bit binary fraction; flag zero, too large and too small
   always_comb begin
      exp8      = bits_ff[30:23];
      mant      = {1'b1, bits_ff[22:0]};
      is_zero   = (bits_ff[30:0] == 31'd0);
      too_large = !is_zero && (exp8 >= EXP_TOO_LARGE);
      too_small = !is_zero && (exp8 < EXP_TOO_SMALL);
      if (exp8 >= EXP_BIAS) begin
         nbits_dec = NBITS_W'(exp8 - EXP_BIAS_M1);
         fpart_dec = mant << NBITS_W'(exp8 - EXP_BIAS_M1);
      end else begin
         nbits_dec = '0;
         fpart_dec = mant >> (EXP_BIAS_M1 - exp8);
      end
   end

   always_comb begin
      n_before = ROOM_W'(neg_ff) + ROOM_W'(nint_ff) + ROOM_W'(1);
      room_buf = BUF_ROOM - n_before;
      room_cap = CHAR_CAP - n_before;
      budget   = FRAC_MAXR;
      if (room_buf < budget) budget = room_buf;
      if (room_cap < budget) budget = room_cap;
   end

   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load  = out_free && (state_ff inside {S_ERR, S_SIGN, S_IDIG, S_DOT, S_FDIG});
   assign frac_last = (FCNT_W'(fptr_ff) == nkeep_ff - FCNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         bcd_cmd_ff.start  <= 1'b0;
         frac_cmd_ff.start <= 1'b0;
         rsp_tvalid_ff     <= 1'b0;
      end else begin
         bcd_cmd_ff.start  <= (state_ff == S_DECODE) && !too_large && !too_small;
         frac_cmd_ff.start <= (state_ff == S_BUDGET);
         if (rsp_load) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  bits_ff  <= req_tdata;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               neg_ff   <= bits_ff[31] && !is_zero;
               fpart_ff <= fpart_dec;
               if (too_large || too_small) begin
                  err_ff   <= too_large ? ST_TOO_LARGE : ST_TOO_SMALL;
                  state_ff <= S_ERR;
               end else begin
                  bcd_cmd_ff.nbits <= nbits_dec;
                  state_ff         <= S_INT;
               end
            end
            S_INT: begin
               if (bcd_stat.done) begin
                  nint_ff  <= (bcd_stat.ndig == 4'd0) ? 4'd1 : bcd_stat.ndig;
                  state_ff <= S_BUDGET;
               end
            end
            S_BUDGET: begin
               frac_cmd_ff.budget <= budget[FCNT_W-1:0];
               state_ff           <= S_FRAC;
            end
            S_FRAC: begin
               if (frac_stat.done) begin
                  nkeep_ff <= frac_stat.nkeep;
                  iptr_ff  <= nint_ff - 4'd1;
                  state_ff <= neg_ff ? S_SIGN : S_IDIG;
               end
            end
            S_ERR: begin
               if (out_free) begin
                  rsp_char_ff   <= CHAR_NONE;
                  rsp_last_ff   <= 1'b1;
                  rsp_status_ff <= err_ff;
                  state_ff      <= S_IDLE;
               end
            end
            S_SIGN: begin
               if (out_free) begin
                  rsp_char_ff   <= ASCII_MINUS;
                  rsp_last_ff   <= 1'b0;
                  rsp_status_ff <= ST_OK;
                  state_ff      <= S_IDIG;
               end
            end
            S_IDIG: begin
               if (out_free) begin
                  rsp_char_ff   <= ASCII_ZERO + {4'b0, bcd_digits[iptr_ff*4 +: 4]};
                  rsp_last_ff   <= 1'b0;
                  rsp_status_ff <= ST_OK;
                  if (iptr_ff == 4'd0) state_ff <= S_DOT;
                  else iptr_ff <= iptr_ff - 4'd1;
               end
            end
            S_DOT: begin
               if (out_free) begin
                  rsp_char_ff   <= ASCII_POINT;
                  rsp_last_ff   <= 1'b0;
                  rsp_status_ff <= ST_OK;
                  fptr_ff       <= '0;
                  state_ff      <= S_FDIG;
               end
            end
            S_FDIG: begin
               if (out_free) begin
                  rsp_char_ff   <= ASCII_ZERO + {4'b0, frac_digit};
                  rsp_last_ff   <= frac_last;
                  rsp_status_ff <= ST_OK;
                  fptr_ff       <= fptr_ff + FIDX_W'(1);
                  if (frac_last) state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tlast && (rsp_tdata == CHAR_NONE))
      else $error("error response not a single empty last character");

   a_ok_text: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_OK) |->
         ((rsp_tdata >= ASCII_ZERO) && (rsp_tdata <= ASCII_NINE)) ||
         (rsp_tdata == ASCII_MINUS) || (rsp_tdata == ASCII_POINT))
      else $error("response character outside number text");

   a_bcd_done: assert property (@(posedge clock) disable iff (reset)
      bcd_stat.done |-> (state_ff == S_INT))
      else $error("BCD unit finished outside integer phase");

   a_frac_done: assert property (@(posedge clock) disable iff (reset)
      frac_stat.done |-> (state_ff == S_FRAC))
      else $error("fraction unit finished outside fraction phase");

   a_budget: assert property (@(posedge clock) disable iff (reset)
      frac_cmd_ff.start |->
         (frac_cmd_ff.budget != '0) && (ROOM_W'(frac_cmd_ff.budget) <= FRAC_MAXR))
      else $error("fraction digit budget out of range");

endmodule

// ----- hw/rtl/f2dt_bcd_unit.sv -----
`timescale 1ns / 1ps
module f2dt_bcd_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  f2dt_pkg::bcd_cmd_type                cmd,
   input  logic [f2dt_pkg::INT_BITS-1:0]        value,
   output f2dt_pkg::bcd_stat_type               stat,
   output logic [f2dt_pkg::INT_DIGITS*4-1:0]    bcd
);
   import f2dt_pkg::*;

   typedef enum logic [1:0] {B_IDLE, B_SHIFT, B_COUNT} bstate_type;

   bstate_type                state_ff;
   logic [INT_BITS-1:0]       shreg_ff;
   logic [INT_DIGITS*4-1:0]   bcd_ff;
   logic [INT_DIGITS*4-1:0]   bcd_adj;
   logic [NBITS_W-1:0]        cnt_ff;
   logic [3:0]                ndig_ff;
   logic [3:0]                ndig_calc;
   logic                      done_ff;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < INT_DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                       : bcd_ff[i*4 +: 4];
      end
   end

   always_comb begin
      ndig_calc = '0;
      for (int i = 0; i < INT_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) ndig_calc = 4'(i + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == B_COUNT);
         unique case (state_ff)
            B_IDLE: begin
               if (cmd.start) begin
                  shreg_ff <= value;
                  bcd_ff   <= '0;
                  cnt_ff   <= cmd.nbits;
                  state_ff <= (cmd.nbits == '0) ? B_COUNT : B_SHIFT;
               end
            end
            B_SHIFT: begin
               bcd_ff   <= {bcd_adj[INT_DIGITS*4-2:0], shreg_ff[INT_BITS-1]};
               shreg_ff <= shreg_ff << 1;
               cnt_ff   <= cnt_ff - NBITS_W'(1);
               if (cnt_ff == NBITS_W'(1)) state_ff <= B_COUNT;
            end
            B_COUNT: begin
               ndig_ff  <= ndig_calc;
               state_ff <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign stat.done = done_ff;
   assign stat.ndig = ndig_ff;
   assign bcd       = bcd_ff;

endmodule

// ----- hw/rtl/f2dt_frac_unit.sv -----
`timescale 1ns / 1ps
module f2dt_frac_unit #(
   parameter int MAX_FRAC_DIGITS = 7
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  f2dt_pkg::frac_cmd_type                cmd,
   input  logic [f2dt_pkg::FRAC_BITS-1:0]        fpart,
   output f2dt_pkg::frac_stat_type               stat,
   input  logic [((MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1)-1:0] rd_idx,
   output logic [3:0]                            rd_digit
);
   import f2dt_pkg::*;

   localparam int FIDX_W = (MAX_FRAC_DIGITS > 1) ? $clog2(MAX_FRAC_DIGITS) : 1;

   typedef enum logic {F_IDLE, F_RUN} fstate_type;

   fstate_type           state_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [FRAC_BITS+3:0] prod;
   logic [FCNT_W-1:0]    cnt_ff;
   logic [FIDX_W-1:0]    pos_ff;
   logic [FCNT_W-1:0]    lastnz_ff;
   logic                 done_ff;
   logic [3:0]           dig_ff [MAX_FRAC_DIGITS];

   // times ten as two shifts and one add; the carry out is the next digit
   assign prod = ({4'b0, frac_ff} << 3) + ({4'b0, frac_ff} << 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == F_RUN) && (cnt_ff == FCNT_W'(1));
         unique case (state_ff)
            F_IDLE: begin
               if (cmd.start) begin
                  frac_ff   <= fpart;
                  cnt_ff    <= cmd.budget;
                  pos_ff    <= '0;
                  lastnz_ff <= '0;
                  state_ff  <= F_RUN;
               end
            end
            F_RUN: begin
               dig_ff[pos_ff] <= prod[FRAC_BITS+3:FRAC_BITS];
               if (prod[FRAC_BITS+3:FRAC_BITS] != 4'd0) begin
                  lastnz_ff <= FCNT_W'(pos_ff) + FCNT_W'(1);
               end
               frac_ff <= prod[FRAC_BITS-1:0];
               pos_ff  <= pos_ff + FIDX_W'(1);
               cnt_ff  <= cnt_ff - FCNT_W'(1);
               if (cnt_ff == FCNT_W'(1)) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   // drop trailing zeros but keep one digit
   assign stat.done  = done_ff;
   assign stat.nkeep = (lastnz_ff == '0) ? FCNT_W'(1) : lastnz_ff;
   assign rd_digit   = dig_ff[rd_idx];

endmodule

// ----- tb/tb_float_to_decimal_text.sv -----
`timescale 1ns / 1ps
module tb_float_to_decimal_text;
   import f2dt_pkg::*;

   localparam int FRAC_DIGIT_CAP = 7;
   localparam int TEXT_BUF_LEN   = 15;
   localparam int LIMIT_CYCLES   = 400000;
   localparam int SETTLE_CYCLES  = 80;

   typedef struct {
      logic [7:0]      ch;
      logic            last;
      conv_status_type status;
   } text_char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   text_char_type pending_chars[$];
   int         error_count = 0;
   int         requests_sent = 0;
   int         chars_checked = 0;
   int         cycle_count = 0;
   int         sender_idle_pct = 0;
   int         rsp_stall_pct = 0;

   float_to_decimal_text #(
      .MAX_FRAC_DIGITS(FRAC_DIGIT_CAP),
      .TEXT_BUFFER_LEN(TEXT_BUF_LEN)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d characters outstanding",
                  cycle_count, pending_chars.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Expected text of one float: sign, integer digits, point, truncated fraction digits, or one empty error character.
   function automatic void predict_text(input logic [31:0] bits);
      int            e;
      int            dot;
      int            budget;
      logic [23:0]   mant;
      logic [31:0]   whole;
      logic [31:0]   frac;
      logic [63:0]   wide;
      logic [7:0]    text[$];
      logic [7:0]    digits[$];
      text_char_type c;
      e = int'(bits[30:23]) - 127;
      mant = {1'b1, bits[22:0]};
      whole = 32'd0;
      frac = 32'd0;
      if (bits[30:0] == 31'd0) begin
         text = '{ASCII_ZERO, ASCII_POINT, ASCII_ZERO};
      end else if (e >= 31 || e < -23) begin
         c.ch = CHAR_NONE;
         c.last = 1'b1;
         c.status = (e >= 31) ? ST_TOO_LARGE : ST_TOO_SMALL;
         pending_chars.push_back(c);
         return;
      end else begin
         if (e >= 23) begin
            whole = 32'(mant) << (e - 23);
         end else if (e >= 0) begin
            whole = 32'(mant) >> (23 - e);
            wide = 64'(mant) << (e + 1);
            frac = {8'd0, wide[23:0]};
         end else begin
            frac = 32'(mant) >> (-(e + 1));
         end
         if (bits[31]) text.push_back(ASCII_MINUS);
         if (whole == 32'd0) begin
            text.push_back(ASCII_ZERO);
         end else begin
            while (whole != 32'd0) begin
               digits.push_front(ASCII_ZERO + 8'(whole % 10));
               whole = whole / 10;
            end
            text = {text, digits};
         end
         text.push_back(ASCII_POINT);
         if (frac == 32'd0) begin
            text.push_back(ASCII_ZERO);
         end else begin
            dot = text.size() - 1;
            budget = TEXT_BUF_LEN - text.size() - 1;
            if (budget > FRAC_DIGIT_CAP) budget = FRAC_DIGIT_CAP;
            if (budget > int'(CHAR_CAP) - int'(text.size()))
               budget = int'(CHAR_CAP) - int'(text.size());
            if (budget < 1) budget = 1;
            for (int i = 0; i < budget; i++) begin
               frac = frac * 10;
               text.push_back(ASCII_ZERO + {4'd0, frac[27:24]});
               frac[31:24] = 8'd0;
            end
            // drop trailing zeros, keep one fraction digit
            while (int'(text.size()) - 1 > dot + 1 && text[$] == ASCII_ZERO)
               void'(text.pop_back());
         end
      end
      while (text.size() > int'(CHAR_CAP)) void'(text.pop_back());
      foreach (text[i]) begin
         c.ch = text[i];
         c.last = (i == text.size() - 1);
         c.status = ST_OK;
         pending_chars.push_back(c);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("character 0x%02h with no request pending", rsp_tdata));
         end else begin
            want = pending_chars.pop_front();
            chars_checked++;
            if (rsp_tdata !== want.ch)
               report_mismatch($sformatf("char got 0x%02h want 0x%02h", rsp_tdata, want.ch));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last got %b want %b", rsp_tlast, want.last));
            if (rsp_tuser !== want.status)
               report_mismatch($sformatf("status got %0d want %s", rsp_tuser,
                                         want.status.name()));
         end
      end
   end

   task automatic send_float(input logic [31:0] bits);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= bits;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_text(bits);
      requests_sent++;
   endtask

   // Hold off new requests until every expected character is back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_chars.size() != 0);
   endtask

   task automatic set_idling(input int sender_pct, input int stall_pct);
      sender_idle_pct = sender_pct;
      rsp_stall_pct = stall_pct;
   endtask

   function automatic logic [31:0] random_float_bits();
      int          pick;
      int          k;
      logic [31:0] bits;
      pick = $urandom_range(99);
      bits = $urandom;
      if (pick < 70) begin
         bits[30:23] = 8'($urandom_range(157, 104));
         // clear low mantissa bits so short, exact fractions show up
         if ($urandom_range(1)) begin
            k = $urandom_range(23);
            bits[22:0] = (bits[22:0] >> k) << k;
         end
      end else if (pick < 85) begin
         bits = $urandom;
      end else if (pick < 93) begin
         bits[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
         if ($urandom_range(1)) bits[22:0] = 23'd0;
      end else begin
         case ($urandom_range(3))
            0: bits[30:23] = EXP_TOO_SMALL - 8'd1;
            1: bits[30:23] = EXP_TOO_SMALL;
            2: bits[30:23] = EXP_TOO_LARGE - 8'd1;
            default: bits[30:23] = EXP_TOO_LARGE;
         endcase
      end
      return bits;
   endfunction

   task automatic test_zero_and_sign();
      send_float(32'h0000_0000);
      send_float(32'h8000_0000);
      send_float(32'h3F80_0000);
      send_float(32'hBF80_0000);
      send_float(32'h3FC0_0000);
      send_float(32'hBE00_0000);
      wait_drained();
   endtask

   task automatic test_range_limits();
      send_float(32'h7F80_0000);
      send_float(32'hFF80_0000);
      send_float(32'h7FC0_0000);
      send_float(32'h4F00_0000);
      send_float(32'h4EFF_FFFF);
      send_float(32'hCEFF_FFFF);
      send_float(32'h0000_0001);
      send_float(32'h0080_0000);
      send_float(32'h33FF_FFFF);
      send_float(32'h3400_0000);
      send_float(32'h347F_FFFF);
      wait_drained();
   endtask

   task automatic test_fraction_digits();
      send_float(32'h4B7F_FFFF);
      send_float(32'h4AFF_FFFF);
      send_float(32'hCAFF_FFFF);
      send_float(32'h3F7F_FFFF);
      send_float(32'h3DCC_CCCD);
      send_float(32'h4120_0000);
      send_float(32'hC2F6_E979);
      wait_drained();
   endtask

   task automatic test_random_conversions(input int count);
      for (int i = 0; i < count; i++) send_float(random_float_bits());
      wait_drained();
   endtask

   task automatic test_pause_until_drained();
      for (int i = 0; i < 5; i++) send_float(random_float_bits());
      wait_drained();
      for (int i = 0; i < 5; i++) send_float(random_float_bits());
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      test_zero_and_sign();
      set_idling(31, 31);
      test_range_limits();
      set_idling(0, 58);
      test_fraction_digits();

      set_idling(0, 0);
      test_random_conversions(18);
      set_idling(58, 0);
      test_random_conversions(18);
      set_idling(0, 58);
      test_random_conversions(18);
      set_idling(31, 31);
      test_random_conversions(18);
      test_pause_until_drained();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0)
         report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));

      $display("Covered zero, signs, range limits, fraction digit budget and random floats");
      $display("under four idling mixes: %0d requests, %0d characters checked, %0d errors",
               requests_sent, chars_checked, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- float_to_decimal_text.f -----
hw/rtl/f2dt_pkg.sv
hw/rtl/f2dt_bcd_unit.sv
hw/rtl/f2dt_frac_unit.sv
hw/rtl/float_to_decimal_text.sv
tb/tb_float_to_decimal_text.sv
